FILE: rtl/cvq_pkg.sv
// cvq_pkg: shared types, constants and register indexes of the vote qualifier
// used by cvq_hist_mem, cvq_scan_alu and classifier_vote_qualifier_core
// no dependencies
package cvq_pkg;

	localparam int LABELS = 8;
	localparam int IDX_W  = (LABELS > 1) ? $clog2(LABELS) : 1;

	localparam int CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] CFG_RUNS_PER_VERDICT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WIN_THRESHOLD    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ERROR_THRESHOLD  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_AMBIGUITY_LIMIT  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_STREAK_LIMIT     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_GOOD_LABEL_MASK  = 3'd5;

	localparam logic [7:0] RST_RUNS_PER_VERDICT = 8'd20;
	localparam logic [7:0] RST_WIN_THRESHOLD    = 8'd10;
	localparam logic [7:0] RST_ERROR_THRESHOLD  = 8'd5;
	localparam logic [3:0] RST_AMBIGUITY_LIMIT  = 4'd3;
	localparam logic [7:0] RST_STREAK_LIMIT     = 8'd3;
	localparam logic [7:0] RST_GOOD_LABEL_MASK  = 8'd122;

	localparam logic [7:0] VOTE_MAX  = 8'd255;
	localparam logic [3:0] COUNT_MAX = 4'd15;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INC,
		ST_PRIME,
		ST_SCAN,
		ST_DONE
	} state_t;

	// running statistics of the histogram scan
	typedef struct packed {
		logic [3:0]       over_win;
		logic [3:0]       over_err;
		logic [IDX_W-1:0] top;
		logic [7:0]       top_votes;
		logic [3:0]       ties;
	} scan_acc_t;

	// histogram memory control from the sequencer
	typedef struct packed {
		logic             we;
		logic [IDX_W-1:0] wr_addr;
		logic [7:0]       wr_data;
		logic [IDX_W-1:0] rd_addr;
		logic             clear;
	} hist_ctrl_t;

endpackage

FILE: rtl/cvq_hist_mem.sv
// cvq_hist_mem: per-label vote histogram, one write and one registered read port
// per-entry valid bits make a cleared entry read as zero; depends on cvq_pkg
module cvq_hist_mem (
	input  logic                clk,
	input  logic                arst_n,
	input  cvq_pkg::hist_ctrl_t ctrl,
	output logic [7:0]          rd_data
);

	logic [7:0]              mem [cvq_pkg::LABELS];
	logic [cvq_pkg::LABELS-1:0] valid_q;
	logic [7:0]              rd_q;
	logic                    rd_valid_q;

	always_ff @(posedge clk) begin
		if (ctrl.we) begin
			mem[ctrl.wr_addr] <= ctrl.wr_data;
		end
		rd_q <= mem[ctrl.rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			rd_valid_q <= valid_q[ctrl.rd_addr];
			if (ctrl.clear) begin
				valid_q <= '0;
			end else if (ctrl.we) begin
				valid_q[ctrl.wr_addr] <= 1'b1;
			end
		end
	end

	assign rd_data = rd_valid_q ? rd_q : 8'd0;

endmodule

FILE: rtl/cvq_scan_alu.sv
// cvq_scan_alu: one histogram entry folded into the running scan statistics
// threshold compares, max search and tie count; depends on cvq_pkg
module cvq_scan_alu (
	input  logic [7:0]                vote,
	input  logic [cvq_pkg::IDX_W-1:0] idx,
	input  logic [7:0]                win_thr,
	input  logic [7:0]                err_thr,
	input  cvq_pkg::scan_acc_t        acc_in,
	output cvq_pkg::scan_acc_t        acc_out
);

	always_comb begin
		acc_out = acc_in;
		if (vote >= win_thr && acc_in.over_win != cvq_pkg::COUNT_MAX) begin
			acc_out.over_win = acc_in.over_win + 4'd1;
		end
		if (vote >= err_thr && acc_in.over_err != cvq_pkg::COUNT_MAX) begin
			acc_out.over_err = acc_in.over_err + 4'd1;
		end
		// equal count bumps ties, a new maximum restarts them
		priority if (vote == acc_in.top_votes) begin
			if (acc_in.ties != cvq_pkg::COUNT_MAX) begin
				acc_out.ties = acc_in.ties + 4'd1;
			end
		end else if (vote > acc_in.top_votes) begin
			acc_out.top       = idx;
			acc_out.top_votes = vote;
			acc_out.ties      = 4'd1;
		end
	end

endmodule

FILE: rtl/classifier_vote_qualifier_core.sv
// classifier_vote_qualifier_core: top level, sequencer, window state and config
// uses cvq_pkg, cvq_hist_mem and cvq_scan_alu
//
// channel | direction | handshake            | payload
// in      | in        | in_valid / in_ready   | winner_label, dsp_time, classify_time
// out     | out       | out_valid / out_ready | verdict fields and time totals
// cfg     | in        | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// a vote that closes no window: accept, then histogram increment
// a vote that closes a window: accept, increment, read prime, one histogram entry
// a cycle through the shared scan unit over the single memory read port, then the
// verdict cycle
// reset loads the config defaults and clears all histogram valid bits at once
// the verdict waits while an earlier result still sits in the output register
module classifier_vote_qualifier_core (
	input  logic                            clk,
	input  logic                            arst_n,
	// input beats
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [2:0]                      winner_label,
	input  logic [15:0]                     dsp_time,
	input  logic [15:0]                     classify_time,
	// result beats
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [3:0]                      labels_over_win,
	output logic [3:0]                      labels_over_error,
	output logic [2:0]                      top_label,
	output logic [7:0]                      top_votes,
	output logic [3:0]                      top_ties,
	output logic                            pass_good,
	output logic                            pass_bad,
	output logic                            fail_high,
	output logic                            fail_single,
	output logic [15:0]                     dsp_time_total,
	output logic [15:0]                     classify_time_total,
	// config writes
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [cvq_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [7:0]                      cfg_data
);

	localparam logic [cvq_pkg::IDX_W-1:0] LAST_IDX = cvq_pkg::IDX_W'(cvq_pkg::LABELS - 1);

	cvq_pkg::state_t state_q, state_d;

	// config registers
	logic [7:0] runs_per_verdict_q;
	logic [7:0] win_threshold_q;
	logic [7:0] error_threshold_q;
	logic [3:0] ambiguity_limit_q;
	logic [7:0] streak_limit_q;
	logic [7:0] good_label_mask_q;

	// window state
	logic [7:0]  run_count_q;
	logic [7:0]  fail_streak_q;
	logic [15:0] dsp_sum_q;
	logic [15:0] classify_sum_q;

	// current vote
	logic [cvq_pkg::IDX_W-1:0] label_q;
	logic                      label_ok_q;

	// scan
	logic [cvq_pkg::IDX_W-1:0] scan_idx_q;
	cvq_pkg::scan_acc_t        acc_q, acc_step;
	cvq_pkg::hist_ctrl_t       hist_ctrl;
	logic [7:0]                hist_rd;

	// output register
	logic        out_valid_q;
	logic [3:0]  over_win_q, over_err_q, ties_q;
	logic [2:0]  top_label_q;
	logic [7:0]  top_votes_q;
	logic        good_q, bad_q, hfail_q, sfail_q;
	logic [15:0] dsp_total_q, classify_total_q;

	logic       in_beat;
	logic       out_free;
	logic       verdict_go;
	logic       label_ok;
	logic       fail;
	logic [7:0] streak_next;
	logic [4:0] top_ext;
	logic       top_good;

	assign in_ready  = (state_q == cvq_pkg::ST_IDLE);
	assign cfg_ready = 1'b1;
	assign in_beat   = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign verdict_go = (state_q == cvq_pkg::ST_DONE) && out_free;

	// labels past the histogram are counted as runs but get no vote
	assign label_ok = (6'(winner_label) < 6'(cvq_pkg::LABELS));

	// verdict from the finished scan
	assign fail        = (acc_q.over_win == 4'd0) || (acc_q.over_err >= ambiguity_limit_q);
	assign streak_next = (fail_streak_q == cvq_pkg::VOTE_MAX) ? cvq_pkg::VOTE_MAX
	                                                          : fail_streak_q + 8'd1;
	// labels eight and up have no mask bit
	assign top_ext  = 5'(acc_q.top);
	assign top_good = (top_ext < 5'd8) && good_label_mask_q[top_ext[2:0]];

	cvq_hist_mem u_hist (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (hist_ctrl),
		.rd_data (hist_rd)
	);

	cvq_scan_alu u_alu (
		.vote    (hist_rd),
		.idx     (scan_idx_q),
		.win_thr (win_threshold_q),
		.err_thr (error_threshold_q),
		.acc_in  (acc_q),
		.acc_out (acc_step)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			cvq_pkg::ST_IDLE: begin
				if (in_beat) begin
					state_d = cvq_pkg::ST_INC;
				end
			end
			cvq_pkg::ST_INC: begin
				state_d = (run_count_q >= runs_per_verdict_q) ? cvq_pkg::ST_PRIME
				                                              : cvq_pkg::ST_IDLE;
			end
			cvq_pkg::ST_PRIME: begin
				state_d = cvq_pkg::ST_SCAN;
			end
			cvq_pkg::ST_SCAN: begin
				if (scan_idx_q == LAST_IDX) begin
					state_d = cvq_pkg::ST_DONE;
				end
			end
			cvq_pkg::ST_DONE: begin
				if (out_free) begin
					state_d = cvq_pkg::ST_IDLE;
				end
			end
			default: state_d = cvq_pkg::ST_IDLE;
		endcase
	end

	// histogram port control
	always_comb begin
		hist_ctrl         = '0;
		hist_ctrl.wr_addr = label_q;
		hist_ctrl.wr_data = (hist_rd == cvq_pkg::VOTE_MAX) ? cvq_pkg::VOTE_MAX
		                                                   : hist_rd + 8'd1;
		unique case (state_q)
			cvq_pkg::ST_IDLE: begin
				hist_ctrl.rd_addr = cvq_pkg::IDX_W'(winner_label);
			end
			cvq_pkg::ST_INC: begin
				hist_ctrl.we = label_ok_q;
			end
			cvq_pkg::ST_PRIME: begin
				hist_ctrl.rd_addr = '0;
			end
			cvq_pkg::ST_SCAN: begin
				// wrap to entry zero after the last one, never past the depth
				hist_ctrl.rd_addr = (scan_idx_q == LAST_IDX) ? '0 : scan_idx_q + 1'b1;
			end
			cvq_pkg::ST_DONE: begin
				hist_ctrl.clear = out_free;
			end
			default: hist_ctrl = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cvq_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// config writes, indexes past the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			runs_per_verdict_q <= cvq_pkg::RST_RUNS_PER_VERDICT;
			win_threshold_q    <= cvq_pkg::RST_WIN_THRESHOLD;
			error_threshold_q  <= cvq_pkg::RST_ERROR_THRESHOLD;
			ambiguity_limit_q  <= cvq_pkg::RST_AMBIGUITY_LIMIT;
			streak_limit_q     <= cvq_pkg::RST_STREAK_LIMIT;
			good_label_mask_q  <= cvq_pkg::RST_GOOD_LABEL_MASK;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				cvq_pkg::CFG_RUNS_PER_VERDICT: runs_per_verdict_q <= cfg_data;
				cvq_pkg::CFG_WIN_THRESHOLD:    win_threshold_q    <= cfg_data;
				cvq_pkg::CFG_ERROR_THRESHOLD:  error_threshold_q  <= cfg_data;
				cvq_pkg::CFG_AMBIGUITY_LIMIT:  ambiguity_limit_q  <= cfg_data[3:0];
				cvq_pkg::CFG_STREAK_LIMIT:     streak_limit_q     <= cfg_data;
				cvq_pkg::CFG_GOOD_LABEL_MASK:  good_label_mask_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// window counters, sums and failure streak
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_count_q    <= '0;
			fail_streak_q  <= '0;
			dsp_sum_q      <= '0;
			classify_sum_q <= '0;
			label_ok_q     <= 1'b0;
		end else begin
			if (in_beat) begin
				run_count_q    <= (run_count_q == cvq_pkg::VOTE_MAX) ? cvq_pkg::VOTE_MAX
				                                                     : run_count_q + 8'd1;
				dsp_sum_q      <= dsp_sum_q + dsp_time;
				classify_sum_q <= classify_sum_q + classify_time;
				label_ok_q     <= label_ok;
			end else if (verdict_go) begin
				run_count_q    <= '0;
				dsp_sum_q      <= '0;
				classify_sum_q <= '0;
			end
			if (verdict_go) begin
				fail_streak_q <= fail ? streak_next : 8'd0;
			end
		end
	end

	// vote label and scan registers
	always_ff @(posedge clk) begin
		if (in_beat) begin
			label_q <= cvq_pkg::IDX_W'(winner_label);
		end
		if (state_q == cvq_pkg::ST_PRIME) begin
			scan_idx_q <= '0;
			acc_q      <= '{over_win: 4'd0, over_err: 4'd0, top: '0, top_votes: 8'd0,
			                ties: 4'd1};
		end else if (state_q == cvq_pkg::ST_SCAN) begin
			scan_idx_q <= (scan_idx_q == LAST_IDX) ? scan_idx_q : scan_idx_q + 1'b1;
			acc_q      <= acc_step;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (verdict_go) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (verdict_go) begin
			over_win_q       <= acc_q.over_win;
			over_err_q       <= acc_q.over_err;
			top_label_q      <= 3'(acc_q.top);
			top_votes_q      <= acc_q.top_votes;
			ties_q           <= acc_q.ties;
			good_q           <= !fail && top_good;
			bad_q            <= !fail && !top_good;
			hfail_q          <= fail && (streak_next >= streak_limit_q);
			sfail_q          <= fail && (streak_next < streak_limit_q);
			dsp_total_q      <= dsp_sum_q;
			classify_total_q <= classify_sum_q;
		end
	end

	assign out_valid           = out_valid_q;
	assign labels_over_win     = over_win_q;
	assign labels_over_error   = over_err_q;
	assign top_label           = top_label_q;
	assign top_votes           = top_votes_q;
	assign top_ties            = ties_q;
	assign pass_good           = good_q;
	assign pass_bad            = bad_q;
	assign fail_high           = hfail_q;
	assign fail_single         = sfail_q;
	assign dsp_time_total      = dsp_total_q;
	assign classify_time_total = classify_total_q;

	// a result only appears out of the verdict cycle
	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == cvq_pkg::ST_DONE))
		else $error("result raised outside the verdict cycle");

	// every result carries exactly one verdict flag
	a_one_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> ($countones({good_q, bad_q, hfail_q, sfail_q}) == 1))
		else $error("result without exactly one verdict flag");

	// an accepted vote always goes to the histogram increment
	a_accept_inc: assert property (@(posedge clk) disable iff (!arst_n)
		in_beat |=> (state_q == cvq_pkg::ST_INC))
		else $error("accepted vote skipped the increment");

	// the scan never walks past the last label
	a_scan_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == cvq_pkg::ST_SCAN) |-> (scan_idx_q <= LAST_IDX))
		else $error("scan index out of range");

endmodule
